FILE: rtl/gsr_pkg.sv
// gsr_pkg: shared types, codes and fixed-point helpers of the relaxed gauss-seidel solver
// used by gsr_div and gauss_seidel_relaxed_solver; no dependencies
`timescale 1ns / 1ps
package gsr_pkg;

  localparam int DATA_W = 32;
  localparam int FRAC_W = 16;
  localparam int PROD_W = 66;

  // input transaction op codes
  localparam logic [1:0] OP_LOAD_COEFF = 2'd0;
  localparam logic [1:0] OP_LOAD_RHS   = 2'd1;
  localparam logic [1:0] OP_SOLVE      = 2'd2;

  // configuration register indexes
  localparam logic [1:0] CFG_SIZE       = 2'd0;
  localparam logic [1:0] CFG_RELAX      = 2'd1;
  localparam logic [1:0] CFG_TOLERANCE  = 2'd2;
  localparam logic [1:0] CFG_MAX_SWEEPS = 2'd3;

  typedef logic signed [DATA_W-1:0] q_t;
  typedef logic signed [PROD_W-1:0] wide_t;

  // clamp a wide value to signed 32 bits
  function automatic q_t sat32(input wide_t v);
    if (v[PROD_W-1:DATA_W-1] == '0 || v[PROD_W-1:DATA_W-1] == '1) begin
      return v[DATA_W-1:0];
    end else if (v[PROD_W-1]) begin
      return {1'b1, {(DATA_W-1){1'b0}}};
    end else begin
      return {1'b0, {(DATA_W-1){1'b1}}};
    end
  endfunction

  // divide by 2^16 truncating toward zero
  function automatic wide_t tdiv16(input wide_t v);
    wide_t t;
    t = v + (v[PROD_W-1] ? wide_t'((1 << FRAC_W) - 1) : wide_t'(0));
    return t >>> FRAC_W;
  endfunction

endpackage

FILE: rtl/gauss_seidel_relaxed_solver.sv
// relaxed gauss-seidel solver: load transactions are accepted while the solver is idle; a solve
// (n unknowns) is paced by the shared 48-step divider and the single multiplier reused
// every element step. results leave one at a time, each held until out_stall is low;
// no new input while a solve runs.
// reset clears control state and loads register defaults; matrix stores are undefined
// until written. depends on gsr_pkg and gsr_div
`timescale 1ns / 1ps
module gauss_seidel_relaxed_solver import gsr_pkg::*; #(
  parameter int MAX_UNKNOWNS = 8
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  op,
  input  logic [2:0]  row,
  input  logic [2:0]  col,
  input  logic signed [31:0] value,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  unknown_index,
  output logic signed [31:0] solution,
  output logic        converged,
  output logic [9:0]  sweeps_used,
  output logic        zero_pivot,
  output logic        last,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [22:0] cfg_data
);

  localparam int IDX_W = $clog2(MAX_UNKNOWNS);
  localparam int AW    = 2 * IDX_W;
  localparam int EXT_W = IDX_W + 4;

  localparam logic [4:0] S_IDLE       = 5'd0;
  localparam logic [4:0] S_PIV_RD     = 5'd1;
  localparam logic [4:0] S_PIV_CHK    = 5'd2;
  localparam logic [4:0] S_NORM_D     = 5'd3;
  localparam logic [4:0] S_NORM_D2    = 5'd4;
  localparam logic [4:0] S_NORM_RD    = 5'd5;
  localparam logic [4:0] S_NORM_START = 5'd6;
  localparam logic [4:0] S_NORM_WAIT  = 5'd7;
  localparam logic [4:0] S_INIT_B     = 5'd8;
  localparam logic [4:0] S_INIT_B2    = 5'd9;
  localparam logic [4:0] S_INIT_RD    = 5'd10;
  localparam logic [4:0] S_INIT_ACC   = 5'd11;
  localparam logic [4:0] S_INIT_WR    = 5'd12;
  localparam logic [4:0] S_SW_ROW     = 5'd13;
  localparam logic [4:0] S_SW_ROW2    = 5'd14;
  localparam logic [4:0] S_SW_RD      = 5'd15;
  localparam logic [4:0] S_SW_MUL     = 5'd16;
  localparam logic [4:0] S_SW_QM      = 5'd17;
  localparam logic [4:0] S_SW_ACC     = 5'd18;
  localparam logic [4:0] S_SW_LAM1    = 5'd19;
  localparam logic [4:0] S_SW_LAM2    = 5'd20;
  localparam logic [4:0] S_SW_LAM3    = 5'd21;
  localparam logic [4:0] S_SW_LAM4    = 5'd22;
  localparam logic [4:0] S_SW_TOL1    = 5'd23;
  localparam logic [4:0] S_SW_TOL2    = 5'd24;
  localparam logic [4:0] S_OUT_RD     = 5'd25;
  localparam logic [4:0] S_OUT_LD     = 5'd26;
  localparam logic [4:0] S_OUT_WAIT   = 5'd27;

  // configuration registers
  logic [3:0]  size_in_use;
  logic [17:0] relax_weight;
  logic [22:0] stop_tolerance;
  logic [9:0]  max_sweeps;

  always_ff @(posedge clk) begin
    if (rst) begin
      size_in_use    <= 4'd3;
      relax_weight   <= 18'd65536;
      stop_tolerance <= 23'd3277;
      max_sweeps     <= 10'd50;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_SIZE:       size_in_use    <= cfg_data[3:0];
        CFG_RELAX:      relax_weight   <= cfg_data[17:0];
        CFG_TOLERANCE:  stop_tolerance <= cfg_data;
        CFG_MAX_SWEEPS: max_sweeps     <= cfg_data[9:0];
      endcase
    end
  end

  // sequencer and control state
  logic [4:0]       state;
  logic [IDX_W-1:0] i;
  logic [IDX_W-1:0] j;
  logic [IDX_W-1:0] nlast;
  logic             do_rhs;
  logic             bad;
  logic             all_ok;
  logic [9:0]       sweeps;

  // datapath registers
  q_t    d_reg;
  q_t    acc;
  q_t    old;
  q_t    qm;
  q_t    xnew;
  wide_t prod;
  wide_t p1;
  wide_t sum;
  logic [DATA_W:0] diff;

  // memories
  q_t coeff_mem [1 << AW];
  q_t a_mem     [1 << AW];
  q_t rhs_mem   [MAX_UNKNOWNS];
  q_t b_mem     [MAX_UNKNOWNS];
  q_t x_mem     [MAX_UNKNOWNS];
  q_t coeff_rdata, a_rdata, rhs_rdata, b_rdata, x_rdata;

  logic             accept;
  logic [EXT_W-1:0] row_ext, col_ext;
  logic             row_ok, col_ok;
  logic             coeff_we, rhs_we;
  logic [AW-1:0]    coeff_raddr;
  logic [IDX_W-1:0] x_raddr;
  logic [IDX_W-1:0] nlast_calc;

  logic             div_start, div_done;
  q_t               div_num, div_quo;

  logic signed [DATA_W:0] ma, mb;
  logic signed [DATA_W:0] one_minus;
  logic [DATA_W:0]        xmag;
  logic signed [DATA_W:0] xdiff;
  logic [56:0]            tol_lhs;
  logic                   fail;
  logic                   ok_next;
  logic [10:0]            sweeps_inc;
  logic [IDX_W+2:0]       i_ext;

  // input handshake and load decode
  assign in_stall = (state != S_IDLE);
  assign accept   = in_valid && !in_stall;
  assign row_ext  = EXT_W'(row);
  assign col_ext  = EXT_W'(col);
  assign row_ok   = 32'(row_ext) < MAX_UNKNOWNS;
  assign col_ok   = 32'(col_ext) < MAX_UNKNOWNS;
  assign coeff_we = accept && op == OP_LOAD_COEFF && row_ok && col_ok;
  assign rhs_we   = accept && op == OP_LOAD_RHS && row_ok;

  // clamp n to 2..MAX_UNKNOWNS, kept as the last index
  always_comb begin
    if (size_in_use < 4'd2) begin
      nlast_calc = IDX_W'(1);
    end else if (32'(size_in_use) > MAX_UNKNOWNS) begin
      nlast_calc = IDX_W'(MAX_UNKNOWNS - 1);
    end else begin
      nlast_calc = IDX_W'(size_in_use - 4'd1);
    end
  end

  assign coeff_raddr = (state == S_NORM_RD) ? {i, j} : {i, i};
  assign x_raddr     = (state == S_SW_RD) ? j : i;

  // stores, registered reads
  always_ff @(posedge clk) begin
    if (coeff_we) begin
      coeff_mem[{row_ext[IDX_W-1:0], col_ext[IDX_W-1:0]}] <= value;
    end
    coeff_rdata <= coeff_mem[coeff_raddr];
  end

  always_ff @(posedge clk) begin
    if (rhs_we) begin
      rhs_mem[row_ext[IDX_W-1:0]] <= value;
    end
    rhs_rdata <= rhs_mem[i];
  end

  always_ff @(posedge clk) begin
    if (state == S_NORM_WAIT && div_done && !do_rhs) begin
      a_mem[{i, j}] <= div_quo;
    end
    a_rdata <= a_mem[{i, j}];
  end

  always_ff @(posedge clk) begin
    if (state == S_NORM_WAIT && div_done && do_rhs) begin
      b_mem[i] <= div_quo;
    end
    b_rdata <= b_mem[i];
  end

  always_ff @(posedge clk) begin
    if (state == S_INIT_WR) begin
      x_mem[i] <= acc;
    end else if (state == S_SW_TOL1) begin
      x_mem[i] <= xnew;
    end
    x_rdata <= x_mem[x_raddr];
  end

  // shared divider
  assign div_start = (state == S_NORM_START);
  assign div_num   = do_rhs ? rhs_rdata : coeff_rdata;

  gsr_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (d_reg),
    .done  (div_done),
    .quo   (div_quo)
  );

  // shared multiplier operand select
  assign one_minus = $signed(33'd65536) - $signed({15'b0, relax_weight});
  assign xmag      = xnew[DATA_W-1] ? (DATA_W+1)'(0) - {xnew[DATA_W-1], xnew}
                                    : {1'b0, xnew};

  always_comb begin
    unique case (state)
      S_SW_MUL: begin
        ma = {a_rdata[DATA_W-1], a_rdata};
        mb = {x_rdata[DATA_W-1], x_rdata};
      end
      S_SW_LAM1: begin
        ma = $signed({15'b0, relax_weight});
        mb = {acc[DATA_W-1], acc};
      end
      S_SW_LAM2: begin
        ma = one_minus;
        mb = {old[DATA_W-1], old};
      end
      default: begin
        ma = $signed({10'b0, stop_tolerance});
        mb = $signed(xmag);
      end
    endcase
  end

  always_ff @(posedge clk) begin
    prod <= wide_t'(ma) * wide_t'(mb);
  end

  // tolerance test and sweep limit
  assign xdiff      = {xnew[DATA_W-1], xnew} - {old[DATA_W-1], old};
  assign tol_lhs    = (57'(diff) * 57'd100) << FRAC_W;
  assign fail       = (xnew != '0) && (tol_lhs > prod[56:0]);
  assign ok_next    = all_ok && !fail;
  assign sweeps_inc = {1'b0, sweeps} + 11'd1;

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      i         <= '0;
      j         <= '0;
      nlast     <= IDX_W'(1);
      do_rhs    <= 1'b0;
      bad       <= 1'b0;
      all_ok    <= 1'b1;
      sweeps    <= '0;
      out_valid <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (accept && op == OP_SOLVE) begin
            i      <= '0;
            bad    <= 1'b0;
            do_rhs <= 1'b0;
            nlast  <= nlast_calc;
            state  <= S_PIV_RD;
          end
        end
        // diagonal scan
        S_PIV_RD: state <= S_PIV_CHK;
        S_PIV_CHK: begin
          if (i == nlast) begin
            i <= '0;
            if (bad || coeff_rdata == '0) begin
              bad    <= 1'b1;
              all_ok <= 1'b0;
              sweeps <= '0;
              state  <= S_OUT_RD;
            end else begin
              state <= S_NORM_D;
            end
          end else begin
            bad   <= bad || coeff_rdata == '0;
            i     <= i + IDX_W'(1);
            state <= S_PIV_RD;
          end
        end
        // row normalization
        S_NORM_D:  state <= S_NORM_D2;
        S_NORM_D2: begin
          d_reg <= coeff_rdata;
          j     <= '0;
          state <= S_NORM_RD;
        end
        S_NORM_RD:    state <= S_NORM_START;
        S_NORM_START: state <= S_NORM_WAIT;
        S_NORM_WAIT: begin
          if (div_done) begin
            if (!do_rhs) begin
              if (j == nlast) begin
                do_rhs <= 1'b1;
              end else begin
                j <= j + IDX_W'(1);
              end
              state <= S_NORM_RD;
            end else begin
              do_rhs <= 1'b0;
              if (i == nlast) begin
                i     <= '0;
                state <= S_INIT_B;
              end else begin
                i     <= i + IDX_W'(1);
                state <= S_NORM_D;
              end
            end
          end
        end
        // initial guess
        S_INIT_B:  state <= S_INIT_B2;
        S_INIT_B2: begin
          acc   <= b_rdata;
          j     <= '0;
          state <= S_INIT_RD;
        end
        S_INIT_RD: state <= S_INIT_ACC;
        S_INIT_ACC: begin
          if (j != i) begin
            acc <= sat32(wide_t'(acc) - wide_t'(a_rdata));
          end
          if (j == nlast) begin
            state <= S_INIT_WR;
          end else begin
            j     <= j + IDX_W'(1);
            state <= S_INIT_RD;
          end
        end
        S_INIT_WR: begin
          if (i == nlast) begin
            i      <= '0;
            sweeps <= '0;
            all_ok <= 1'b1;
            state  <= S_SW_ROW;
          end else begin
            i     <= i + IDX_W'(1);
            state <= S_INIT_B;
          end
        end
        // one row of a sweep
        S_SW_ROW:  state <= S_SW_ROW2;
        S_SW_ROW2: begin
          acc   <= b_rdata;
          old   <= x_rdata;
          j     <= '0;
          state <= S_SW_RD;
        end
        S_SW_RD:  state <= S_SW_MUL;
        S_SW_MUL: state <= S_SW_QM;
        S_SW_QM: begin
          qm    <= sat32(tdiv16(prod));
          state <= S_SW_ACC;
        end
        S_SW_ACC: begin
          if (j != i) begin
            acc <= sat32(wide_t'(acc) - wide_t'(qm));
          end
          if (j == nlast) begin
            state <= S_SW_LAM1;
          end else begin
            j     <= j + IDX_W'(1);
            state <= S_SW_RD;
          end
        end
        S_SW_LAM1: state <= S_SW_LAM2;
        S_SW_LAM2: begin
          p1    <= prod;
          state <= S_SW_LAM3;
        end
        S_SW_LAM3: begin
          sum   <= p1 + prod;
          state <= S_SW_LAM4;
        end
        S_SW_LAM4: begin
          xnew  <= sat32(tdiv16(sum));
          state <= S_SW_TOL1;
        end
        S_SW_TOL1: begin
          diff  <= xdiff[DATA_W] ? (DATA_W+1)'(0) - xdiff : xdiff;
          state <= S_SW_TOL2;
        end
        S_SW_TOL2: begin
          if (i == nlast) begin
            i      <= '0;
            sweeps <= sweeps_inc[9:0];
            if (!ok_next && sweeps_inc < {1'b0, max_sweeps}) begin
              all_ok <= 1'b1;
              state  <= S_SW_ROW;
            end else begin
              all_ok <= ok_next;
              state  <= S_OUT_RD;
            end
          end else begin
            all_ok <= ok_next;
            i      <= i + IDX_W'(1);
            state  <= S_SW_ROW;
          end
        end
        // result transactions
        S_OUT_RD: state <= S_OUT_LD;
        S_OUT_LD: begin
          out_valid <= 1'b1;
          state     <= S_OUT_WAIT;
        end
        S_OUT_WAIT: begin
          if (!out_stall) begin
            out_valid <= 1'b0;
            if (i == nlast) begin
              state <= S_IDLE;
            end else begin
              i     <= i + IDX_W'(1);
              state <= S_OUT_RD;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // output payload
  assign i_ext = (IDX_W+3)'(i);

  always_ff @(posedge clk) begin
    if (state == S_OUT_LD) begin
      unknown_index <= i_ext[2:0];
      solution      <= bad ? '0 : x_rdata;
      converged     <= all_ok;
      sweeps_used   <= sweeps;
      zero_pivot    <= bad;
      last          <= (i == nlast);
    end
  end

endmodule

FILE: rtl/gsr_div.sv
// gsr_div: iterative signed divider giving sat32((num * 2^16) / den), truncating toward zero
// one quotient bit per cycle; depends on gsr_pkg
`timescale 1ns / 1ps
module gsr_div import gsr_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  input  q_t         num,
  input  q_t         den,
  output logic       done,
  output q_t         quo
);

  localparam int QW = DATA_W + FRAC_W;
  localparam int CW = $clog2(QW);
  localparam logic [QW-1:0] MAG_MIN = QW'(1) << (DATA_W - 1);

  logic              busy;
  logic              fin;
  logic [CW-1:0]     cnt;
  logic [DATA_W:0]   rem;
  logic [QW-1:0]     dq;
  logic [DATA_W-1:0] dmag;
  logic              neg;

  logic [DATA_W:0]   num_mag;
  logic [DATA_W:0]   den_mag;
  logic [DATA_W:0]   rem_sh;
  logic              ge;

  // operand magnitudes
  assign num_mag = num[DATA_W-1] ? (DATA_W+1)'(0) - {num[DATA_W-1], num} : {1'b0, num};
  assign den_mag = den[DATA_W-1] ? (DATA_W+1)'(0) - {den[DATA_W-1], den} : {1'b0, den};

  // restoring step
  assign rem_sh = {rem[DATA_W-1:0], dq[QW-1]};
  assign ge     = rem_sh >= {1'b0, dmag};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      fin  <= 1'b0;
    end else begin
      fin <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && cnt == CW'(QW - 1)) begin
        busy <= 1'b0;
        fin  <= 1'b1;
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (start) begin
      cnt  <= '0;
      rem  <= '0;
      dq   <= {num_mag[DATA_W-1:0], {FRAC_W{1'b0}}};
      dmag <= den_mag[DATA_W-1:0];
      neg  <= num[DATA_W-1] ^ den[DATA_W-1];
    end else if (busy) begin
      cnt <= cnt + CW'(1);
      rem <= ge ? rem_sh - {1'b0, dmag} : rem_sh;
      dq  <= {dq[QW-2:0], ge};
    end
  end

  // sign and saturation of the quotient
  always_comb begin
    if (neg) begin
      quo = (dq > MAG_MIN) ? {1'b1, {(DATA_W-1){1'b0}}} : DATA_W'(0) - dq[DATA_W-1:0];
    end else begin
      quo = (dq >= MAG_MIN) ? {1'b0, {(DATA_W-1){1'b1}}} : dq[DATA_W-1:0];
    end
  end

  assign done = fin;

endmodule
